[design/fcd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the focus countdown timer.
// No dependencies; all other files reference this package by scoped names.
package fcd_pkg;

	localparam int NREGS      = 4;
	localparam int SLOTS      = 4;
	localparam int SLOT_W     = 2;
	localparam int COUNT_W    = 3;
	localparam int MIN_W      = 11;
	localparam int MS_W       = 27;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int COUNT_MAX  = (SLOTS < NREGS) ? SLOTS : NREGS;

	localparam logic [MS_W-1:0]  MS_PER_MIN    = 27'd60000;
	localparam logic [MIN_W-1:0] DEFAULT_MIN   = 11'd30;
	localparam logic [MS_W-1:0]  DEFAULT_TOTAL = 27'd1800000;

	// input op codes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_DOUBLE = 2'd1;
	localparam logic [1:0] OP_TRIPLE = 2'd2;
	localparam logic [1:0] OP_RESET  = 2'd3;

	// run states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_PAUSE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUR0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUR_LAST = 3'(NREGS);

	typedef struct packed {
		logic [1:0] op;
		logic       on_focus_screen;
	} in_item_t;

	typedef struct packed {
		logic              completed;
		logic              handled;
		logic [1:0]        run_status;
		logic              switch_allowed;
		logic [MS_W-1:0]   remaining_ms;
		logic [MIN_W-1:0]  active_minutes;
		logic [SLOT_W-1:0] slot_index;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]               eff_count;
		logic [NREGS-1:0][MIN_W-1:0]      mins;
		logic [NREGS-1:0][MS_W-1:0]       total;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        run;
		logic [MS_W-1:0]   elapsed;
		logic [SLOT_W-1:0] slot;
	} timer_state_t;

endpackage

[design/focus_countdown_timer_top.sv]
`timescale 1ns / 1ps
// Top level of the focus countdown timer: config registers, timer state,
// event logic and the result register. Uses fcd_pkg, fcd_cfg and fcd_step.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data): one beat per event, a
//   millisecond tick, a double press, a triple press or a session reset.
//   Output channel (out_valid / out_ready / out_data): exactly one result
//   beat per input beat, in order, describing the timer after that event.
//   Config port (cfg_we / cfg_index / cfg_data): index 0 is the slot count,
//   indexes 1..4 the slot lengths in minutes; other indexes are dropped.
//   Write it only while no result is outstanding.
// Timing: a result is registered and appears in the cycle after its event
//   is taken; one event per cycle is sustained while out_ready is high. The
//   rate is set by the single result register, updated with the timer state.
// Reset: arst_n clears the timer to idle, elapsed zero, slot zero, and the
//   config to count 0, slot zero 30 minutes, others default.
// Stall: while out_ready is low a held result keeps in_ready low; as soon
//   as the held beat is taken a new event is accepted in the same cycle.
module focus_countdown_timer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fcd_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fcd_pkg::out_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [fcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	fcd_pkg::cfg_t         cfg;
	fcd_pkg::timer_state_t state_q;
	fcd_pkg::timer_state_t state_nxt;
	fcd_pkg::out_item_t    res;
	fcd_pkg::out_item_t    out_q;
	logic                  out_valid_q;
	logic                  accept;

	fcd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fcd_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (in_data),
		.nxt  (state_nxt),
		.res  (res)
	);

	// accept whenever the result slot is empty or being drained this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// advance the timer state on every accepted event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.run     <= fcd_pkg::ST_IDLE;
			state_q.elapsed <= '0;
			state_q.slot    <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// result valid: set on accept, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload: hold until the next accepted event
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[design/fcd_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers: clamped slot count, per-slot minutes with the
// default applied, and per-slot session length in ms. Uses fcd_pkg.
module fcd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output fcd_pkg::cfg_t                   cfg
);

	logic [fcd_pkg::COUNT_W-1:0] count_raw;
	logic [fcd_pkg::COUNT_W-1:0] count_clamped;
	logic [fcd_pkg::MIN_W-1:0]   mins_wr;
	logic [fcd_pkg::MS_W-1:0]    total_wr;
	logic [fcd_pkg::SLOT_W-1:0]  slot_wr;
	logic                        dur_hit;

	assign count_raw     = cfg_data[fcd_pkg::COUNT_W-1:0];
	assign count_clamped = (count_raw > fcd_pkg::COUNT_W'(fcd_pkg::COUNT_MAX))
		? fcd_pkg::COUNT_W'(fcd_pkg::COUNT_MAX) : count_raw;
	// zero minutes means the default length
	assign mins_wr  = (cfg_data[fcd_pkg::MIN_W-1:0] == '0)
		? fcd_pkg::DEFAULT_MIN : cfg_data[fcd_pkg::MIN_W-1:0];
	assign total_wr = fcd_pkg::MS_W'(mins_wr) * fcd_pkg::MS_PER_MIN;
	assign slot_wr  = fcd_pkg::SLOT_W'(cfg_index - fcd_pkg::REG_DUR0);
	assign dur_hit  = (cfg_index >= fcd_pkg::REG_DUR0) && (cfg_index <= fcd_pkg::REG_DUR_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.eff_count <= '0;
			for (int i = 0; i < fcd_pkg::NREGS; i++) begin
				cfg.mins[i]  <= fcd_pkg::DEFAULT_MIN;
				cfg.total[i] <= fcd_pkg::DEFAULT_TOTAL;
			end
		end else if (cfg_we) begin
			if (cfg_index == fcd_pkg::REG_COUNT) begin
				cfg.eff_count <= count_clamped;
			end else if (dur_hit) begin
				cfg.mins[slot_wr]  <= mins_wr;
				cfg.total[slot_wr] <= total_wr;
			end
		end
	end

endmodule

[design/fcd_step.sv]
`timescale 1ns / 1ps
// Next-state and result logic for one event of the timer.
// Purely combinational; uses fcd_pkg types and codes.
module fcd_step (
	input  fcd_pkg::cfg_t          cfg,
	input  fcd_pkg::timer_state_t  cur,
	input  fcd_pkg::in_item_t      item,
	output fcd_pkg::timer_state_t  nxt,
	output fcd_pkg::out_item_t     res
);

	logic [1:0]                  run;
	logic [fcd_pkg::COUNT_W-1:0] cnt;
	logic [fcd_pkg::SLOT_W-1:0]  idx_old;
	logic [fcd_pkg::SLOT_W-1:0]  idx_new;
	logic [fcd_pkg::SLOT_W-1:0]  slot_inc;
	logic [fcd_pkg::MS_W-1:0]    total_old;
	logic [fcd_pkg::MS_W-1:0]    total_new;
	logic [fcd_pkg::MIN_W-1:0]   mins_new;
	logic                        completed;
	logic                        handled;

	function automatic logic [fcd_pkg::SLOT_W-1:0] clamp_slot(
		input logic [fcd_pkg::SLOT_W-1:0]  s,
		input logic [fcd_pkg::COUNT_W-1:0] c
	);
		return (fcd_pkg::COUNT_W'(s) >= c) ? fcd_pkg::SLOT_W'(c - 1'b1) : s;
	endfunction

	// (s + 1) mod c for c in 1..4
	function automatic logic [fcd_pkg::SLOT_W-1:0] next_slot(
		input logic [fcd_pkg::SLOT_W-1:0]  s,
		input logic [fcd_pkg::COUNT_W-1:0] c
	);
		logic [fcd_pkg::COUNT_W-1:0] v;
		v = fcd_pkg::COUNT_W'(s) + 1'b1;
		case (c)
			3'd1:    return '0;
			3'd2:    return {1'b0, v[0]};
			3'd3:    return (v >= 3'd3) ? fcd_pkg::SLOT_W'(v - 3'd3) : fcd_pkg::SLOT_W'(v);
			default: return fcd_pkg::SLOT_W'(v);
		endcase
	endfunction

	assign run       = (cur.run > fcd_pkg::ST_PAUSE) ? fcd_pkg::ST_IDLE : cur.run;
	assign cnt       = cfg.eff_count;
	assign idx_old   = clamp_slot(cur.slot, cnt);
	assign total_old = (cnt == '0) ? fcd_pkg::DEFAULT_TOTAL : cfg.total[idx_old];
	assign slot_inc  = next_slot(cur.slot, cnt);

	always_comb begin
		nxt       = cur;
		nxt.run   = run;
		completed = 1'b0;
		handled   = 1'b0;
		case (item.op)
			fcd_pkg::OP_TICK: begin
				if (run == fcd_pkg::ST_RUN) begin
					// saturating advance: done once elapsed + 1 reaches the total
					if (cur.elapsed >= total_old - 1'b1) begin
						nxt.run     = fcd_pkg::ST_IDLE;
						nxt.elapsed = '0;
						completed   = 1'b1;
					end else begin
						nxt.elapsed = cur.elapsed + 1'b1;
					end
				end
			end
			fcd_pkg::OP_DOUBLE: begin
				if (item.on_focus_screen && run == fcd_pkg::ST_IDLE) begin
					if (cnt != '0) begin
						nxt.slot = slot_inc;
					end
					handled = 1'b1;
				end
			end
			fcd_pkg::OP_TRIPLE: begin
				if (item.on_focus_screen) begin
					if (run == fcd_pkg::ST_IDLE) begin
						nxt.elapsed = '0;
						nxt.run     = fcd_pkg::ST_RUN;
					end else if (run == fcd_pkg::ST_RUN) begin
						nxt.run = fcd_pkg::ST_PAUSE;
					end else begin
						nxt.run = fcd_pkg::ST_RUN;
					end
					handled = 1'b1;
				end
			end
			default: begin
				nxt.run     = fcd_pkg::ST_IDLE;
				nxt.elapsed = '0;
			end
		endcase
	end

	assign idx_new   = clamp_slot(nxt.slot, cnt);
	assign total_new = (cnt == '0) ? fcd_pkg::DEFAULT_TOTAL : cfg.total[idx_new];
	assign mins_new  = (cnt == '0) ? fcd_pkg::DEFAULT_MIN : cfg.mins[idx_new];

	assign res.completed      = completed;
	assign res.handled        = handled;
	assign res.run_status     = nxt.run;
	assign res.switch_allowed = !(item.on_focus_screen && nxt.run == fcd_pkg::ST_RUN);
	assign res.remaining_ms   = (nxt.elapsed >= total_new) ? '0 : total_new - nxt.elapsed;
	assign res.active_minutes = mins_new;
	assign res.slot_index     = nxt.slot;

endmodule

[design/fcd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the focus countdown timer, bound to the top level.
// Uses fcd_pkg codes.
module fcd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input fcd_pkg::in_item_t               in_data,
	input logic                            out_valid,
	input logic                            out_ready,
	input fcd_pkg::out_item_t              out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// with no result pending the block takes an event
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

	// a session reset yields an idle, unhandled result next cycle
	a_reset_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.op == fcd_pkg::OP_RESET
		|=> out_valid && out_data.run_status == fcd_pkg::ST_IDLE && !out_data.handled
		&& !out_data.completed)
		else $error("session reset result wrong");

	// a press off the focus screen is never handled
	a_off_screen: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.on_focus_screen
		|=> out_valid && !out_data.handled)
		else $error("press handled off the focus screen");

	// completion always lands in idle and is not a press
	a_completion: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.completed
		|-> out_data.run_status == fcd_pkg::ST_IDLE && !out_data.handled
		&& out_data.switch_allowed)
		else $error("completion with bad status");

endmodule

bind focus_countdown_timer_top fcd_checker u_fcd_checker (.*);
